// ----- rtl/lmz_pkg.sv -----
// Shared constants and types for the 3x3 local-minimum zeroing block.
`default_nettype none

package lmz_pkg;

    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int MAX_HEIGHT_DEF  = 1024;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 11;
    localparam int MIN_DIM        = 2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // set where the centre sample has no neighbour on that side
    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } edge_mask_t;

endpackage

`default_nettype wire

// ----- rtl/lmz_ram.sv -----
// Generic simple dual-port RAM with registered read and read enable.
`default_nettype none

module lmz_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/lmz_min_cmp.sv -----
// Strict 3x3 local-minimum test of the centre sample against in-frame neighbours.
`default_nettype none

module lmz_min_cmp #(
    parameter int SAMPLE_BITS = lmz_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic [2:0][SAMPLE_BITS-1:0] col_left,   // [0] top .. [2] bottom
    input  wire logic [2:0][SAMPLE_BITS-1:0] col_mid,
    input  wire logic [2:0][SAMPLE_BITS-1:0] col_right,
    input  wire lmz_pkg::edge_mask_t         edges,
    output logic                             is_min
);

    logic signed [SAMPLE_BITS-1:0] centre;
    logic                          row_ok;

    assign centre = $signed(col_mid[1]);

    always_comb begin
        is_min = 1'b1;
        row_ok = 1'b0;
        for (int r = 0; r < 3; r++) begin
            row_ok = !((r == 0 && edges.top) || (r == 2 && edges.bottom));
            if (row_ok && !edges.left && !(centre < $signed(col_left[r]))) begin
                is_min = 1'b0;
            end
            if (row_ok && r != 1 && !(centre < $signed(col_mid[r]))) begin
                is_min = 1'b0;
            end
            if (row_ok && !edges.right && !(centre < $signed(col_right[r]))) begin
                is_min = 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/local_minimum_zeroing_3x3.sv -----
// Top level: raster 3x3 strict local-minimum detector with line store RAM.
//
//  channel | dir | handshake              | payload
//  s_      | in  | s_tvalid / s_tready    | tdata: pixel_value; tuser: command
//  m_      | out | m_tvalid / m_tready    | tdata: pixel_out; tuser: is_local_min; tlast: frame_end
//  cfg_    | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data (image_width, image_height)
//
// One request per cycle sustained while m_ does not stall; a request passes the window
// stage (RAM read), then the compare into the output register.
// Output sample p appears with input p + width + 1; drains flush the remaining width + 1 outputs.
// Synchronous active-low reset clears counters, valids and sets both sizes to 2.
// No clearing pass: line store entries are always written in a frame before use.
// Stalls on m_ hold one request in the window stage; s_tready then drops.
`default_nettype none

module local_minimum_zeroing_3x3 #(
    parameter int MAX_WIDTH   = lmz_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = lmz_pkg::MAX_HEIGHT_DEF,
    parameter int SAMPLE_BITS = lmz_pkg::SAMPLE_BITS_DEF,
    localparam int TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [TDATA_BITS-1:0]                s_tdata,   // pixel_value
    input  wire logic                                 s_tuser,   // command
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic      [TDATA_BITS-1:0]                m_tdata,   // pixel_out
    output logic                                      m_tuser,   // is_local_min
    output logic                                      m_tlast,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [lmz_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [lmz_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    localparam int COL_BITS  = $clog2(MAX_WIDTH);
    localparam int DIMW_BITS = $clog2(MAX_WIDTH + 1);
    localparam int ROW_BITS  = $clog2(MAX_HEIGHT + 1);

    // ---------------- configuration and counters ----------------
    logic [DIMW_BITS-1:0] w_reg, w_next, w_last;
    logic [ROW_BITS-1:0]  h_reg, h_next, h_last;
    logic [COL_BITS-1:0]  in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [ROW_BITS-1:0]  in_row_reg, in_row_next, out_row_reg, out_row_next;

    // ---------------- window stage ----------------
    logic                          s1_valid_reg, s1_valid_next;
    logic                          s1_pixel_reg, s1_pixel_next;
    logic                          s1_emit_reg, s1_emit_next;
    logic                          s1_last_reg, s1_last_next;
    logic [COL_BITS-1:0]           s1_col_reg, s1_col_next;
    logic [SAMPLE_BITS-1:0]        s1_x_reg, s1_x_next;
    lmz_pkg::edge_mask_t           s1_edges_reg, s1_edges_next;
    logic [2:0][SAMPLE_BITS-1:0]   win_left_reg, win_left_next;
    logic [2:0][SAMPLE_BITS-1:0]   win_mid_reg, win_mid_next;
    logic [2:0][SAMPLE_BITS-1:0]   col_new;

    // ---------------- output register ----------------
    logic                   out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0] pix_out_reg, pix_out_next;
    logic                   min_reg, min_next;
    logic                   last_reg, last_next;

    // ---------------- request decode ----------------
    logic                   s_accept, is_drain, in_done, restart, take, emit, out_last;
    logic                   cfg_hit, s1_adv, is_min;
    logic [COL_BITS-1:0]    base_in_col, base_out_col, drain_addr, rd_addr;
    logic [ROW_BITS-1:0]    base_in_row, base_out_row;
    logic [DIMW_BITS-1:0]   cfg_w;
    logic [ROW_BITS-1:0]    cfg_h;
    logic [2*SAMPLE_BITS-1:0] rd_data, wr_data;
    logic                   ram_we;

    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid && (cfg_index == lmz_pkg::REG_IMAGE_WIDTH ||
                                     cfg_index == lmz_pkg::REG_IMAGE_HEIGHT);

    always_comb begin
        if (32'(cfg_data) < 32'(lmz_pkg::MIN_DIM)) begin
            cfg_w = DIMW_BITS'(lmz_pkg::MIN_DIM);
        end else if (32'(cfg_data) > 32'(MAX_WIDTH)) begin
            cfg_w = DIMW_BITS'(MAX_WIDTH);
        end else begin
            cfg_w = DIMW_BITS'(cfg_data);
        end
        if (32'(cfg_data) < 32'(lmz_pkg::MIN_DIM)) begin
            cfg_h = ROW_BITS'(lmz_pkg::MIN_DIM);
        end else if (32'(cfg_data) > 32'(MAX_HEIGHT)) begin
            cfg_h = ROW_BITS'(MAX_HEIGHT);
        end else begin
            cfg_h = ROW_BITS'(cfg_data);
        end
    end

    assign w_last = w_reg - DIMW_BITS'(1);
    assign h_last = h_reg - ROW_BITS'(1);

    assign s1_adv   = s1_valid_reg && (!s1_emit_reg || !out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign s_accept = s_tvalid && s_tready;

    assign is_drain = (s_tuser == lmz_pkg::CMD_DRAIN);
    assign in_done  = (in_row_reg == h_reg);
    assign restart  = !is_drain && in_done;

    assign base_in_col  = restart ? '0 : in_col_reg;
    assign base_in_row  = restart ? '0 : in_row_reg;
    assign base_out_col = restart ? '0 : out_col_reg;
    assign base_out_row = restart ? '0 : out_row_reg;

    assign take = !is_drain || in_done;
    assign emit = is_drain ? in_done
                           : (base_in_row > ROW_BITS'(1) ||
                              (base_in_row == ROW_BITS'(1) && base_in_col != '0));
    assign out_last = (base_out_row == h_last) &&
                      (DIMW_BITS'(base_out_col) == w_last);

    assign drain_addr = (DIMW_BITS'(out_col_reg) == w_last) ? '0
                                                            : out_col_reg + COL_BITS'(1);
    assign rd_addr    = is_drain ? drain_addr : base_in_col;

    always_comb begin
        w_next       = w_reg;
        h_next       = h_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (cfg_hit) begin
            if (cfg_index == lmz_pkg::REG_IMAGE_WIDTH) begin
                w_next = cfg_w;
            end else begin
                h_next = cfg_h;
            end
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end else if (s_accept && take) begin
            in_col_next  = base_in_col;
            in_row_next  = base_in_row;
            out_col_next = base_out_col;
            out_row_next = base_out_row;
            if (!is_drain) begin
                if (DIMW_BITS'(base_in_col) == w_last) begin
                    in_col_next = '0;
                    in_row_next = base_in_row + ROW_BITS'(1);
                end else begin
                    in_col_next = base_in_col + COL_BITS'(1);
                end
            end
            if (emit) begin
                if (DIMW_BITS'(base_out_col) == w_last) begin
                    out_col_next = '0;
                    out_row_next = base_out_row + ROW_BITS'(1);
                end else begin
                    out_col_next = base_out_col + COL_BITS'(1);
                end
                if (out_last) begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
            end
        end
    end

    // ---------------- line store: entry holds {row r-2, row r-1} ----------------
    assign ram_we  = s1_adv && s1_pixel_reg;
    assign wr_data = {rd_data[SAMPLE_BITS-1:0], s1_x_reg};

    lmz_ram #(
        .WIDTH (2 * SAMPLE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (s1_col_reg),
        .wr_data (wr_data),
        .rd_en   (s_accept && take),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign col_new[0] = rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign col_new[1] = rd_data[SAMPLE_BITS-1:0];
    assign col_new[2] = s1_x_reg;

    lmz_min_cmp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_min_cmp (
        .col_left  (win_left_reg),
        .col_mid   (win_mid_reg),
        .col_right (col_new),
        .edges     (s1_edges_reg),
        .is_min    (is_min)
    );

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_accept && take) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
        s1_pixel_next = s1_pixel_reg;
        s1_emit_next  = s1_emit_reg;
        s1_last_next  = s1_last_reg;
        s1_col_next   = s1_col_reg;
        s1_x_next     = s1_x_reg;
        s1_edges_next = s1_edges_reg;
        if (s_accept && take) begin
            s1_pixel_next        = !is_drain;
            s1_emit_next         = emit;
            s1_last_next         = out_last;
            s1_col_next          = rd_addr;
            s1_x_next            = s_tdata[SAMPLE_BITS-1:0];
            s1_edges_next.top    = (base_out_row == '0);
            s1_edges_next.bottom = (base_out_row == h_last);
            s1_edges_next.left   = (base_out_col == '0);
            s1_edges_next.right  = (DIMW_BITS'(base_out_col) == w_last);
        end
        win_left_next = win_left_reg;
        win_mid_next  = win_mid_reg;
        if (s1_adv) begin
            win_left_next = win_mid_reg;
            win_mid_next  = col_new;
        end
        out_valid_next = out_valid_reg;
        pix_out_next   = pix_out_reg;
        min_next       = min_reg;
        last_next      = last_reg;
        if (s1_adv && s1_emit_reg) begin
            out_valid_next = 1'b1;
            pix_out_next   = is_min ? '0 : win_mid_reg[1];
            min_next       = is_min;
            last_next      = s1_last_reg;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg         <= DIMW_BITS'(lmz_pkg::MIN_DIM);
            h_reg         <= ROW_BITS'(lmz_pkg::MIN_DIM);
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            w_reg         <= w_next;
            h_reg         <= h_next;
            in_col_reg    <= in_col_next;
            in_row_reg    <= in_row_next;
            out_col_reg   <= out_col_next;
            out_row_reg   <= out_row_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_pixel_reg <= s1_pixel_next;
        s1_emit_reg  <= s1_emit_next;
        s1_last_reg  <= s1_last_next;
        s1_col_reg   <= s1_col_next;
        s1_x_reg     <= s1_x_next;
        s1_edges_reg <= s1_edges_next;
        win_left_reg <= win_left_next;
        win_mid_reg  <= win_mid_next;
        pix_out_reg  <= pix_out_next;
        min_reg      <= min_next;
        last_reg     <= last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_BITS'(pix_out_reg);
    assign m_tuser  = min_reg;
    assign m_tlast  = last_reg;

    // ---------------- checks ----------------
    a_no_rw_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we && s_accept && take |-> s1_col_reg != rd_addr)
        else $error("line store read and write hit the same column");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_col_reg))
        else $error("window stage lost a stalled request");

    a_idle_drain_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && is_drain && !in_done && !cfg_hit |=> !s1_valid_reg)
        else $error("drain outside flush entered the window stage");

    a_counters_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        DIMW_BITS'(in_col_reg) < w_reg && DIMW_BITS'(out_col_reg) < w_reg &&
        out_row_reg < h_reg && in_row_reg <= h_reg)
        else $error("frame counters out of range");

    a_min_zeroed: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && min_reg |-> pix_out_reg == '0)
        else $error("local minimum not zeroed");

endmodule

`default_nettype wire

// ----- tb/sv/tb_local_minimum_zeroing_3x3.sv -----
// Self-checking stream testbench for the 3x3 local-minimum zeroing block.

typedef struct {
    logic [15:0] pixel;
    logic        is_min;
    logic        frame_end;
} minimum_result_t;

class minimum_scoreboard;
    // four rows in rotation: line stores plus the window
    logic signed [15:0] row_ring [4][lmz_pkg::MAX_WIDTH_DEF];
    int unsigned        width;
    int unsigned        height;
    int unsigned        in_count;
    int unsigned        out_count;
    int unsigned        failures;
    int unsigned        results_seen;
    minimum_result_t    expected_q [$];

    function new();
        foreach (row_ring[r, c]) row_ring[r][c] = '0;
        width        = lmz_pkg::MIN_DIM;
        height       = lmz_pkg::MIN_DIM;
        in_count     = 0;
        out_count    = 0;
        failures     = 0;
        results_seen = 0;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function int unsigned clamp_dim(logic [lmz_pkg::CFG_DATA_BITS-1:0] value, int unsigned hi);
        if (value < lmz_pkg::MIN_DIM) return lmz_pkg::MIN_DIM;
        if (value > hi) return hi;
        return value;
    endfunction

    function void apply_register(logic [lmz_pkg::CFG_INDEX_BITS-1:0] index,
                                 logic [lmz_pkg::CFG_DATA_BITS-1:0] value);
        case (index)
            lmz_pkg::REG_IMAGE_WIDTH: begin
                width = clamp_dim(value, lmz_pkg::MAX_WIDTH_DEF);
            end
            lmz_pkg::REG_IMAGE_HEIGHT: begin
                height = clamp_dim(value, lmz_pkg::MAX_HEIGHT_DEF);
            end
            default: begin
                return;
            end
        endcase
        // frame in progress is dropped
        in_count  = 0;
        out_count = 0;
    endfunction

    function void produce_output();
        int                 row;
        int                 col;
        int                 nr;
        int                 nc;
        logic signed [15:0] centre;
        bit                 lowest;
        minimum_result_t    res;
        row    = int'(out_count / width);
        col    = int'(out_count % width);
        centre = row_ring[row % 4][col];
        lowest = 1'b1;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                nr = row + dr;
                nc = col + dc;
                if ((dr != 0 || dc != 0) && nr >= 0 && nr < int'(height) &&
                    nc >= 0 && nc < int'(width)) begin
                    if (!(centre < row_ring[nr % 4][nc])) lowest = 1'b0;
                end
            end
        end
        res.pixel  = lowest ? 16'd0 : centre;
        res.is_min = lowest;
        out_count++;
        res.frame_end = (out_count >= width * height);
        if (res.frame_end) begin
            out_count = 0;
            in_count  = 0;
        end
        expected_q.push_back(res);
    endfunction

    function void note_request(logic command, logic [15:0] sample);
        int unsigned total;
        total = width * height;
        if (command == lmz_pkg::CMD_PIXEL) begin
            // pixel after a finished frame starts a new one, pending outputs dropped
            if (in_count >= total) begin
                in_count  = 0;
                out_count = 0;
            end
            row_ring[(in_count / width) % 4][in_count % width] = sample;
            in_count++;
            if (out_count < total && (in_count >= total || in_count > out_count + width + 1))
                produce_output();
        end else if (in_count >= total && out_count < total) begin
            produce_output();
        end
    endfunction

    task report_mismatch(string what);
        failures++;
        if (failures <= 50) $display("mismatch at result %0d: %s", results_seen, what);
    endtask

    task check_result(logic [15:0] pixel, logic is_min, logic last);
        minimum_result_t want;
        results_seen++;
        if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result, pixel_out %0d", $signed(pixel)));
            return;
        end
        want = expected_q.pop_front();
        if (pixel !== want.pixel)
            report_mismatch($sformatf("pixel_out %0d, expected %0d",
                                      $signed(pixel), $signed(want.pixel)));
        if (is_min !== want.is_min)
            report_mismatch($sformatf("is_local_min %b, expected %b", is_min, want.is_min));
        if (last !== want.frame_end)
            report_mismatch($sformatf("frame_end %b, expected %b", last, want.frame_end));
    endtask
endclass

module tb_local_minimum_zeroing_3x3;
    timeunit 1ns;
    timeprecision 1ps;
    import lmz_pkg::*;

    localparam int IDLE_PERCENT  = 20;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 6;
    localparam int STALL_LIMIT   = 3000;
    localparam int SMALL_ITEMS   = 700;
    localparam int PARTIAL_ITEMS = 64;
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNMAPPED = 2'd3;

    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [15:0]               s_tdata   = '0;
    logic                      s_tuser   = CMD_PIXEL;
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [15:0]               m_tdata;
    logic                      m_tuser;
    logic                      m_tlast;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

    minimum_scoreboard sb;
    bit                steady_run   = 1'b0;
    bit                hold_request = 1'b0;

    local_minimum_zeroing_3x3 dut (
        .aclk,
        .aresetn,
        .s_tvalid,
        .s_tready,
        .s_tdata,
        .s_tuser,
        .m_tvalid,
        .m_tready,
        .m_tdata,
        .m_tuser,
        .m_tlast,
        .cfg_valid,
        .cfg_ready,
        .cfg_index,
        .cfg_data
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic logic [15:0] random_sample();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0:       return 16'h8000;
                    1:       return 16'h7FFF;
                    2:       return 16'h0000;
                    default: return 16'hFFFF;
                endcase
            end
            1, 2: begin
                return 16'($urandom);
            end
            // narrow range so ties and minima are common
            default: begin
                return 16'($urandom_range(0, 6) - 3);
            end
        endcase
    endfunction

    task automatic send_request(input logic command, input logic [15:0] sample);
        while (!steady_run && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= command;
        s_tdata  <= sample;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(command, sample);
    endtask

    task automatic send_frame(input int unsigned cols, input int unsigned rows,
                              input bit noisy, input int unsigned drains);
        for (int unsigned i = 0; i < cols * rows; i++) begin
            if (noisy && i != 0 && $urandom_range(0, 19) == 0)
                send_request(CMD_DRAIN, 16'($urandom));
            send_request(CMD_PIXEL, random_sample());
        end
        repeat (drains) send_request(CMD_DRAIN, 16'($urandom));
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        // requests that produce nothing may still be in the pipe
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] index,
                                  input logic [CFG_DATA_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        sb.apply_register(index, value);
    endtask

    task automatic set_size(input logic [CFG_DATA_BITS-1:0] cols,
                            input logic [CFG_DATA_BITS-1:0] rows);
        write_register(REG_IMAGE_WIDTH, cols);
        write_register(REG_IMAGE_HEIGHT, rows);
        cfg_valid <= 1'b0;
    endtask

    // result side
    initial begin
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
            end
            m_tready <= steady_run || ($urandom_range(0, 99) >= IDLE_PERCENT);
            @(posedge aclk);
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
        end
    end

    // watchdog: ends the run after a long spell with no transfer anywhere
    initial begin
        int unsigned quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int unsigned cols;
        int unsigned rows;
        int unsigned frames;
        int unsigned drains;
        int unsigned small_items;
        bit          big_phase;
        sb = new();
        small_items = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // reset size 2x2: extremes, drain mid-frame, drain with nothing pending
        send_request(CMD_PIXEL, 16'h8000);
        send_request(CMD_DRAIN, 16'h1234);
        send_request(CMD_PIXEL, 16'h7FFF);
        send_request(CMD_PIXEL, 16'h0000);
        send_request(CMD_PIXEL, 16'hFFFF);
        repeat (4) send_request(CMD_DRAIN, 16'hFFFF);

        // flat frame, then a new frame abandons its pending outputs
        repeat (4) send_request(CMD_PIXEL, 16'd5);
        send_request(CMD_DRAIN, 16'h0000);
        repeat (3) send_request(CMD_PIXEL, 16'h7FFF);
        send_request(CMD_PIXEL, 16'h8000);
        repeat (3) send_request(CMD_DRAIN, 16'h0000);

        // partial frame dropped by a size change
        send_request(CMD_PIXEL, 16'd9);
        send_request(CMD_PIXEL, 16'd3);
        wait_for_results();
        set_size(11'd3, 11'd3);

        // single minimum in the centre of a 3x3 frame
        for (int i = 0; i < 9; i++) send_request(CMD_PIXEL, (i == 4) ? 16'd1 : 16'd4);
        repeat (4) send_request(CMD_DRAIN, 16'h0000);
        wait_for_results();

        // unmapped index is ignored; undersized values clamp to 2
        write_register(REG_UNMAPPED, 11'h7FF);
        set_size(11'd1, 11'd0);
        send_frame(2, 2, 1'b0, 3);

        for (int phase = 0; small_items < SMALL_ITEMS || phase < 6; phase++) begin
            wait_for_results();
            big_phase = 1'b0;
            case (phase)
                1: begin
                    cols = MAX_WIDTH_DEF;
                    rows = 2;
                    big_phase = 1'b1;
                    set_size(11'd1025, 11'd2);
                end
                3: begin
                    cols = 2;
                    rows = MAX_HEIGHT_DEF;
                    big_phase = 1'b1;
                    set_size(11'd2, 11'h7FF);
                end
                5: begin
                    cols = 2;
                    rows = 2;
                    set_size(11'd2, 11'd1024);
                    set_size(11'd2, 11'd2);
                end
                default: begin
                    cols = $urandom_range(2, 12);
                    rows = $urandom_range(2, 8);
                    set_size(cols[10:0], rows[10:0]);
                end
            endcase
            steady_run   = (phase == 4);
            hold_request = (phase == 2);
            frames = big_phase ? 1 : ((phase == 4) ? 6 : $urandom_range(1, 4));
            repeat (frames) begin
                if (big_phase) begin
                    // start of a frame at the clamped size, dropped by the next size change
                    for (int i = 0; i < PARTIAL_ITEMS; i++)
                        send_request(CMD_PIXEL, random_sample());
                    small_items += PARTIAL_ITEMS;
                end else begin
                    case ($urandom_range(0, 9))
                        0:       drains = cols + 1 - $urandom_range(1, cols);
                        1:       drains = cols + 1 + $urandom_range(1, 3);
                        default: drains = cols + 1;
                    endcase
                    small_items += cols * rows + drains;
                    send_frame(cols, rows, $urandom_range(0, 3) == 0, drains);
                end
            end
        end
        steady_run = 1'b0;

        wait_for_results();
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

// ----- files.f -----
rtl/lmz_pkg.sv
rtl/lmz_ram.sv
rtl/lmz_min_cmp.sv
rtl/local_minimum_zeroing_3x3.sv
tb/sv/tb_local_minimum_zeroing_3x3.sv
